// ===== src/id_to_name_table_scan_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the id-to-name table scan block
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ID_TO_NAME_TABLE_SCAN_MACROS_SVH
`define ID_TO_NAME_TABLE_SCAN_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every edge out of reset
`define ITN_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ITN_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// ante at an edge implies cons at the next edge
`define ITN_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define ITN_ASSERT_ALWAYS(lbl, ck, rs, cond, msg)
`define ITN_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`define ITN_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

// ===== src/itn_pkg.sv =====
// ----------------------------------------------------------------------------
// itn_pkg
// Shared constants, codes and types of the id-to-name table scan block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itn_pkg;

  // Image layout
  localparam int HEADER_BYTES = 16;
  localparam int ENTRY_BYTES  = 16;
  localparam int NAME_CHARS   = 14;
  localparam int MAX_ENTRIES  = 256;

  // Name field is cut to what fits behind the two id bytes
  localparam int NAME_FIELD = (NAME_CHARS < ENTRY_BYTES - 2) ? NAME_CHARS : ENTRY_BYTES - 2;

  localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES + 1);

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int PTR_W      = $clog2(OUTQ_DEPTH);
  localparam int LEVEL_W    = $clog2(OUTQ_DEPTH + 1);

  // Header bytes
  localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h44, 8'h43, 8'h41}; // "MDCA"
  localparam logic [7:0] POS_VERSION = 8'd4;
  localparam logic [7:0] POS_COUNT_LO = 8'd6;
  localparam logic [7:0] POS_COUNT_HI = 8'd7;

  // Character bounds
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Request function codes
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRY,
    PH_NAME,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OC_FOUND       = 3'd0,
    OC_NOT_FOUND   = 3'd1,
    OC_BAD_MAGIC   = 3'd2,
    OC_BAD_VERSION = 3'd3,
    OC_ID_ZERO     = 3'd4,
    OC_EMPTY_NAME  = 3'd5
  } outcome_t;

  // Everything one request produces: an optional character, then an
  // optional final item.
  typedef struct packed {
    logic       has_char;
    logic [7:0] name_char;
    logic       has_final;
    outcome_t   outcome;
  } itn_group_t;

endpackage

`default_nettype wire

// ===== src/itn_ifs.sv =====
// ----------------------------------------------------------------------------
// itn channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itn_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] query_id;
  logic [7:0]  image_byte;

  modport source (output valid, func, query_id, image_byte, input ready);
  modport sink   (input valid, func, query_id, image_byte, output ready);
endinterface

interface itn_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] name_char;
  logic [2:0] outcome;
  logic       last;

  modport source (output valid, kind, name_char, outcome, last, input ready);
  modport sink   (input valid, kind, name_char, outcome, last, output ready);
endinterface

interface itn_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/itn_step.sv =====
// ----------------------------------------------------------------------------
// itn_step
// Request register, scan state and the per-byte decision logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itn_step import itn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  itn_req_if.sink              req,
  itn_cfg_if.sink              cfg,
  input  logic [LEVEL_W-1:0]   level,
  output logic                 push,
  output itn_group_t           group
);

  // request register
  logic        in_v;
  logic        in_func;
  logic [15:0] in_qid;
  logic [7:0]  in_byte;

  logic [7:0] expected_version;

  phase_t                 phase, phase_next;
  logic [7:0]             byte_pos, byte_pos_next;
  logic [ENTRY_IDX_W-1:0] entry_index, entry_index_next;
  logic [15:0]            entry_total, entry_total_next;
  logic [15:0]            wanted_id, wanted_id_next;
  logic [7:0]             id_high_byte, id_high_byte_next;
  logic [4:0]             chars_emitted, chars_emitted_next;

  logic                   accept;
  logic                   name_ok;
  logic                   magic_bad;
  logic                   ver_bad;
  logic                   hdr_last;
  logic                   ent_last;
  logic                   name_last;
  logic                   id_match;
  logic [15:0]            total_upd;
  logic [ENTRY_IDX_W-1:0] total_clamped;
  logic [ENTRY_IDX_W-1:0] idx_inc;
  logic                   table_end;

  // one group can still be in flight from the request register
  assign req.ready = !rst &&
    (({1'b0, level} + (LEVEL_W+1)'(in_v)) <= (LEVEL_W+1)'(OUTQ_DEPTH - 1));
  assign accept    = req.valid && req.ready;
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= accept;
    end
    if (accept) begin
      in_func <= req.func;
      in_qid  <= req.query_id;
      in_byte <= req.image_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg.valid && cfg.ready) begin
      expected_version <= cfg.data;
    end
  end

  assign name_ok   = ((in_byte >= CH_A) && (in_byte <= CH_Z)) ||
                     ((in_byte >= CH_ZERO) && (in_byte <= CH_NINE));
  assign magic_bad = (byte_pos < 8'd4) && (in_byte != MAGIC[byte_pos[1:0]]);
  assign ver_bad   = (byte_pos == POS_VERSION) && (in_byte != expected_version);
  assign hdr_last  = byte_pos >= 8'(HEADER_BYTES - 1);
  assign ent_last  = byte_pos >= 8'(ENTRY_BYTES - 1);
  assign name_last = ({1'b0, byte_pos} - 9'd1) >= 9'(NAME_FIELD);
  assign id_match  = (byte_pos == 8'd1) && ({id_high_byte, in_byte} == wanted_id);

  always_comb begin
    total_upd = entry_total;
    if (byte_pos == POS_COUNT_LO) begin
      total_upd = {entry_total[15:8], in_byte};
    end else if (byte_pos == POS_COUNT_HI) begin
      total_upd = {in_byte, entry_total[7:0]};
    end
  end

  assign total_clamped = (total_upd > 16'(MAX_ENTRIES)) ? ENTRY_IDX_W'(MAX_ENTRIES)
                                                       : total_upd[ENTRY_IDX_W-1:0];
  assign idx_inc   = entry_index + ENTRY_IDX_W'(1);
  assign table_end = 16'(idx_inc) >= entry_total;

  // next state
  always_comb begin
    phase_next         = phase;
    byte_pos_next      = byte_pos;
    entry_index_next   = entry_index;
    entry_total_next   = entry_total;
    wanted_id_next     = wanted_id;
    id_high_byte_next  = id_high_byte;
    chars_emitted_next = chars_emitted;
    if (in_v) begin
      if (in_func == FUNC_BEGIN) begin
        wanted_id_next     = in_qid;
        byte_pos_next      = 8'd0;
        entry_index_next   = '0;
        entry_total_next   = 16'd0;
        id_high_byte_next  = 8'd0;
        chars_emitted_next = 5'd0;
        phase_next         = (in_qid == 16'd0) ? PH_DONE : PH_HEADER;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            entry_total_next = total_upd;
            if (magic_bad || ver_bad) begin
              phase_next = PH_DONE;
            end else if (hdr_last) begin
              entry_total_next = 16'(total_clamped);
              byte_pos_next    = 8'd0;
              entry_index_next = '0;
              phase_next       = (total_clamped == '0) ? PH_DONE : PH_ENTRY;
            end else begin
              byte_pos_next = byte_pos + 8'd1;
            end
          end
          PH_ENTRY: begin
            if (byte_pos == 8'd0) begin
              id_high_byte_next = in_byte;
            end
            if (id_match) begin
              phase_next         = PH_NAME;
              chars_emitted_next = 5'd0;
              byte_pos_next      = 8'd2;
            end else if (ent_last) begin
              byte_pos_next    = 8'd0;
              entry_index_next = idx_inc;
              if (table_end) begin
                phase_next = PH_DONE;
              end
            end else begin
              byte_pos_next = byte_pos + 8'd1;
            end
          end
          PH_NAME: begin
            byte_pos_next = byte_pos + 8'd1;
            if (name_ok) begin
              chars_emitted_next = chars_emitted + 5'd1;
            end
            if (!name_ok || name_last) begin
              phase_next = PH_DONE;
            end
          end
          PH_IDLE, PH_DONE: begin
            phase_next = phase;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // results of the registered request
  always_comb begin
    group = '{has_char: 1'b0, name_char: 8'd0, has_final: 1'b0, outcome: OC_FOUND};
    if (in_v) begin
      if (in_func == FUNC_BEGIN) begin
        if (in_qid == 16'd0) begin
          group.has_final = 1'b1;
          group.outcome   = OC_ID_ZERO;
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (magic_bad) begin
              group.has_final = 1'b1;
              group.outcome   = OC_BAD_MAGIC;
            end else if (ver_bad) begin
              group.has_final = 1'b1;
              group.outcome   = OC_BAD_VERSION;
            end else if (hdr_last && (total_clamped == '0)) begin
              group.has_final = 1'b1;
              group.outcome   = OC_NOT_FOUND;
            end
          end
          PH_ENTRY: begin
            if (!id_match && ent_last && table_end) begin
              group.has_final = 1'b1;
              group.outcome   = OC_NOT_FOUND;
            end
          end
          PH_NAME: begin
            group.has_char  = name_ok;
            group.name_char = name_ok ? in_byte : 8'd0;
            group.has_final = !name_ok || name_last;
            group.outcome   = (name_ok || (chars_emitted != 5'd0)) ? OC_FOUND : OC_EMPTY_NAME;
          end
          default: begin
            group.has_final = 1'b0;
          end
        endcase
      end
    end
  end

  assign push = group.has_char || group.has_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_pos      <= 8'd0;
      entry_index   <= '0;
      entry_total   <= 16'd0;
      wanted_id     <= 16'd0;
      id_high_byte  <= 8'd0;
      chars_emitted <= 5'd0;
    end else begin
      phase         <= phase_next;
      byte_pos      <= byte_pos_next;
      entry_index   <= entry_index_next;
      entry_total   <= entry_total_next;
      wanted_id     <= wanted_id_next;
      id_high_byte  <= id_high_byte_next;
      chars_emitted <= chars_emitted_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/itn_outq.sv =====
// ----------------------------------------------------------------------------
// itn_outq
// Result group queue; hands out a group's character and final item in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itn_outq import itn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  itn_group_t         group,
  itn_res_if.source          res,
  output logic [LEVEL_W-1:0] level
);

  itn_group_t         mem [OUTQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] count;
  logic               char_sent;

  itn_group_t head;
  logic       show_char;
  logic       take;
  logic       pop;

  assign head      = mem[rd_ptr];
  assign show_char = head.has_char && !char_sent;
  assign take      = res.valid && res.ready;
  // a group holding both items stays for a second handshake
  assign pop       = take && !(show_char && head.has_final);

  assign res.valid     = count != '0;
  assign res.kind      = show_char ? KIND_CHAR : KIND_FINAL;
  assign res.name_char = show_char ? head.name_char : 8'd0;
  assign res.outcome   = show_char ? OC_FOUND : head.outcome;
  assign res.last      = !show_char;
  assign level         = count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      char_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + LEVEL_W'(push) - LEVEL_W'(pop);
      if (take) begin
        char_sent <= !pop;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/id_to_name_table_scan.sv =====
// A taken request passes the request register, then the result queue, before its first result shows.
// Throughput: one request per cycle while req.ready is high; the output side moves one result per
//   cycle while res.ready is high; a matching name byte that also closes the lookup leaves as two results.
// Request ready drops during reset and when the four-group result queue may fill up.
// Reset (rst, synchronous, active high) returns the scan to idle, empties the
//   result queue and sets expected_version to 1.
// ----------------------------------------------------------------------------
// id_to_name_table_scan
// Looks up a 16-bit id in a streamed address-book image and returns its name.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "id_to_name_table_scan_macros.svh"

module id_to_name_table_scan import itn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  itn_req_if.sink    req,
  itn_res_if.source  res,
  itn_cfg_if.sink    cfg
);

  // Datapath overview
  //   itn_step registers each request, then decides combinationally what the
  //   byte means for the current phase (header check, entry id compare, name
  //   character filter) and updates the scan state.
  //   Whatever that request produces (a character, a final item or both)
  //   is written as one group into itn_outq, which sends the items out in
  //   order over the result channel.

  logic               push;
  itn_group_t         group;
  logic [LEVEL_W-1:0] level;

  itn_step u_step (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cfg   (cfg),
    .level (level),
    .push  (push),
    .group (group)
  );

  itn_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .group (group),
    .res   (res),
    .level (level)
  );

  // queue flow control must never let a group be written into a full queue
  `ITN_ASSERT_IMPL(a_no_overflow, clk, rst, push, level < LEVEL_W'(OUTQ_DEPTH), "result queue overflow")

  // a begin with id zero closes the lookup in the cycle after it is taken
  `ITN_ASSERT_NEXT(a_id_zero, clk, rst, req.valid && req.ready && (req.func == FUNC_BEGIN) && (req.query_id == 16'd0), push && group.has_final && (group.outcome == OC_ID_ZERO), "id zero not answered")

  // only letters and digits leave as name characters
  `ITN_ASSERT_IMPL(a_char_set, clk, rst, push && group.has_char, ((group.name_char >= CH_A) && (group.name_char <= CH_Z)) || ((group.name_char >= CH_ZERO) && (group.name_char <= CH_NINE)), "bad name character")

  // final items carry a defined outcome code
  `ITN_ASSERT_IMPL(a_final_code, clk, rst, res.valid && (res.kind == KIND_FINAL), res.last && (res.outcome <= 3'(OC_EMPTY_NAME)), "bad final item")

endmodule

`default_nettype wire
